// ----- src/cpt_pkg.sv -----
`timescale 1ns / 1ps

package cpt_pkg;

  localparam int DATA_BITS    = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int THETA_BITS   = 16;
  localparam int ACC_BITS     = DATA_BITS + 20;
  localparam int TRIG_BITS    = 17;
  localparam int Q15_BITS     = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int CORDIC_BITS  = 34;
  localparam int CORDIC_ZBITS = 26;
  localparam int ZFULL_BITS   = 24;

  typedef logic signed [DATA_BITS-1:0]    data_t;
  typedef logic signed [ACC_BITS-1:0]     acc_t;
  typedef logic signed [TRIG_BITS-1:0]    trig_t;
  typedef logic signed [Q15_BITS-1:0]     q15_t;
  typedef logic signed [CORDIC_BITS-1:0]  cordic_t;
  typedef logic signed [CORDIC_ZBITS-1:0] cordic_z_t;

  typedef enum logic [2:0] {
    OP_CLARKE     = 3'd0,
    OP_INV_CLARKE = 3'd1,
    OP_PARK       = 3'd2,
    OP_INV_PARK   = 3'd3,
    OP_FWD_CHAIN  = 3'd4,
    OP_INV_CHAIN  = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]                  op;
    logic [THETA_BITS-1:0]       theta;
    logic signed [DATA_BITS-1:0] in_first;
    logic signed [DATA_BITS-1:0] in_second;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] out_first;
    logic signed [DATA_BITS-1:0] out_second;
    logic signed [DATA_BITS-1:0] out_third;
  } result_t;

  // coefficients scaled by 2^16
  localparam logic signed [17:0] K_INV_SQRT3     = 18'sd37837;
  localparam logic signed [17:0] K_TWO_INV_SQRT3 = 18'sd75674;
  localparam logic signed [17:0] K_SQRT3_HALF    = 18'sd56756;
  localparam logic signed [17:0] K_NEG_HALF      = -18'sd32768;

  localparam cordic_t CORDIC_X0 = 34'sd652032874;

  localparam cordic_z_t ATAN [CORDIC_STEPS] = '{
    26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050, 26'sd166669, 26'sd83416,
    26'sd41718, 26'sd20860, 26'sd10430, 26'sd5215, 26'sd2608, 26'sd1304,
    26'sd652, 26'sd326, 26'sd163, 26'sd81, 26'sd41, 26'sd20
  };

  localparam acc_t D_MAX = acc_t'((longint'(1) <<< (DATA_BITS - 1)) - longint'(1));
  localparam acc_t D_MIN = -D_MAX - acc_t'(1);

  localparam cordic_t Q_ROUND = 34'sd16384;
  localparam cordic_t Q_MAX   = 34'sd32767;
  localparam cordic_t Q_MIN   = -34'sd32768;

  // round half up, then saturate to the data range
  function automatic data_t rsat(input acc_t acc, input int unsigned sh);
    acc_t t;
    t = (acc + (acc_t'(1) <<< (sh - 1))) >>> sh;
    if (t > D_MAX) begin
      t = D_MAX;
    end else if (t < D_MIN) begin
      t = D_MIN;
    end
    return t[DATA_BITS-1:0];
  endfunction

  function automatic q15_t to_q15(input cordic_t v);
    cordic_t t;
    t = (v + Q_ROUND) >>> 15;
    if (t > Q_MAX) begin
      t = Q_MAX;
    end else if (t < Q_MIN) begin
      t = Q_MIN;
    end
    return t[Q15_BITS-1:0];
  endfunction

endpackage

// ----- src/clarke_park_transform.sv -----
// clarke/park transform unit, one word in and one word out per cycle unless result_stall
// stages: the 18-step cordic sine/cosine chain plus capture, quantize, rotate and
// phase stages
// throughput: one word per cycle; a stage holds only if it and all later ones are full
// reset: synchronous, clears all stage valid bits; no memories, no clearing pass
`timescale 1ns / 1ps

module clarke_park_transform #(
  parameter int ANGLE_BITS = cpt_pkg::ANGLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  cpt_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output cpt_pkg::result_t result
);

  localparam int QS         = cpt_pkg::CORDIC_STEPS + 1;
  localparam int ST_ROT_MUL = QS + 1;
  localparam int ST_ROT_SUM = QS + 2;
  localparam int ST_IC_MUL  = QS + 3;
  localparam int ST_OUT     = QS + 4;
  localparam int NST        = QS + 5;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  // a stage loads unless the output stalls and every stage from it on is full
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !result_stall || !(&vld[NST-1:k]);
  end

  assign sample_stall = !en[0];
  assign result_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= sample_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // capture
  logic [2:0]            op0;
  logic [ANGLE_BITS-1:0] ang0;
  cpt_pkg::data_t        a0;
  cpt_pkg::data_t        b0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      op0  <= sample.op;
      ang0 <= sample.theta[cpt_pkg::THETA_BITS-1 -: ANGLE_BITS];
      a0   <= sample.in_first;
      b0   <= sample.in_second;
    end
  end

  // clarke products
  logic [2:0]     op1;
  cpt_pkg::data_t a1;
  cpt_pkg::data_t b1;
  cpt_pkg::acc_t  ma1;
  cpt_pkg::acc_t  mb1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op1 <= op0;
      a1  <= a0;
      b1  <= b0;
      ma1 <= a0 * cpt_pkg::K_INV_SQRT3;
      mb1 <= b0 * cpt_pkg::K_TWO_INV_SQRT3;
    end
  end

  // clarke result, then a delay line that waits for sine and cosine
  logic [2:0]     op_d [2:QS];
  cpt_pkg::data_t p1_d [2:QS];
  cpt_pkg::data_t p2_d [2:QS];
  cpt_pkg::data_t p2_next;

  always_comb begin
    if (op1 == cpt_pkg::OP_CLARKE || op1 == cpt_pkg::OP_FWD_CHAIN) begin
      p2_next = cpt_pkg::rsat(ma1 + mb1, 16);
    end else begin
      p2_next = b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      op_d[2] <= op1;
      p1_d[2] <= a1;
      p2_d[2] <= p2_next;
    end
    for (int k = 3; k <= QS; k++) begin
      if (en[k]) begin
        op_d[k] <= op_d[k-1];
        p1_d[k] <= p1_d[k-1];
        p2_d[k] <= p2_d[k-1];
      end
    end
  end

  cpt_pkg::trig_t cos_val;
  cpt_pkg::trig_t sin_val;

  cpt_sincos #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sincos (
    .clk    (clk),
    .step_en(en[QS:1]),
    .ang    (ang0),
    .cos_val(cos_val),
    .sin_val(sin_val)
  );

  // rotation products
  logic [2:0]     op20;
  cpt_pkg::data_t p1_20;
  cpt_pkg::data_t p2_20;
  cpt_pkg::acc_t  cc1;
  cpt_pkg::acc_t  cc2;
  cpt_pkg::acc_t  ss1;
  cpt_pkg::acc_t  ss2;

  always_ff @(posedge clk) begin
    if (en[ST_ROT_MUL]) begin
      op20  <= op_d[QS];
      p1_20 <= p1_d[QS];
      p2_20 <= p2_d[QS];
      cc1   <= cos_val * p1_d[QS];
      cc2   <= cos_val * p2_d[QS];
      ss1   <= sin_val * p1_d[QS];
      ss2   <= sin_val * p2_d[QS];
    end
  end

  // park or inverse park sums
  logic [2:0]     op21;
  cpt_pkg::data_t q1;
  cpt_pkg::data_t q2;
  cpt_pkg::data_t q1_next;
  cpt_pkg::data_t q2_next;

  always_comb begin
    case (op20) inside
      cpt_pkg::OP_PARK, cpt_pkg::OP_FWD_CHAIN: begin
        q1_next = cpt_pkg::rsat(cc1 + ss2, 15);
        q2_next = cpt_pkg::rsat(cc2 - ss1, 15);
      end
      cpt_pkg::OP_INV_PARK, cpt_pkg::OP_INV_CHAIN: begin
        q1_next = cpt_pkg::rsat(cc1 - ss2, 15);
        q2_next = cpt_pkg::rsat(ss1 + cc2, 15);
      end
      default: begin
        q1_next = p1_20;
        q2_next = p2_20;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_ROT_SUM]) begin
      op21 <= op20;
      q1   <= q1_next;
      q2   <= q2_next;
    end
  end

  // inverse clarke products
  logic [2:0]     op22;
  cpt_pkg::data_t q1_22;
  cpt_pkg::data_t q2_22;
  cpt_pkg::acc_t  mh;
  cpt_pkg::acc_t  mk;

  always_ff @(posedge clk) begin
    if (en[ST_IC_MUL]) begin
      op22  <= op21;
      q1_22 <= q1;
      q2_22 <= q2;
      mh    <= q1 * cpt_pkg::K_NEG_HALF;
      mk    <= q2 * cpt_pkg::K_SQRT3_HALF;
    end
  end

  // output word
  cpt_pkg::result_t result_next;

  always_comb begin
    case (op22) inside
      cpt_pkg::OP_INV_CLARKE, cpt_pkg::OP_INV_CHAIN: begin
        result_next.out_first  = q1_22;
        result_next.out_second = cpt_pkg::rsat(mh + mk, 16);
        result_next.out_third  = cpt_pkg::rsat(mh - mk, 16);
      end
      cpt_pkg::OP_CLARKE, cpt_pkg::OP_PARK, cpt_pkg::OP_INV_PARK,
      cpt_pkg::OP_FWD_CHAIN: begin
        result_next.out_first  = q1_22;
        result_next.out_second = q2_22;
        result_next.out_third  = '0;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !sample_stall)
    else $error("input stalled while output side is draining");

  a_full_and_blocked: assert property (@(posedge clk) disable iff (rst)
    ((&vld) && result_stall) |-> sample_stall)
    else $error("input taken while every stage is full and blocked");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ----- src/cpt_sincos.sv -----
`timescale 1ns / 1ps

module cpt_sincos #(
  parameter int ANGLE_BITS = cpt_pkg::ANGLE_BITS
) (
  input  logic                              clk,
  input  logic [cpt_pkg::CORDIC_STEPS:0]    step_en,
  input  logic [ANGLE_BITS-1:0]             ang,
  output cpt_pkg::trig_t                    cos_val,
  output cpt_pkg::trig_t                    sin_val
);

  localparam int STEPS = cpt_pkg::CORDIC_STEPS;

  logic [cpt_pkg::ZFULL_BITS-1:0] z24;
  cpt_pkg::cordic_t   xr [1:STEPS];
  cpt_pkg::cordic_t   yr [1:STEPS];
  cpt_pkg::cordic_z_t zr [1:STEPS];
  logic [1:0]         qr [1:STEPS];

  assign z24 = {ang, {(cpt_pkg::ZFULL_BITS - ANGLE_BITS){1'b0}}};

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    cpt_pkg::cordic_t   xin;
    cpt_pkg::cordic_t   yin;
    cpt_pkg::cordic_z_t zin;
    logic [1:0]         qin;

    if (i == 0) begin : g_first
      assign xin = cpt_pkg::CORDIC_X0;
      assign yin = '0;
      assign zin = cpt_pkg::cordic_z_t'(z24[cpt_pkg::ZFULL_BITS-3:0]);
      assign qin = z24[cpt_pkg::ZFULL_BITS-1 -: 2];
    end else begin : g_rest
      assign xin = xr[i];
      assign yin = yr[i];
      assign zin = zr[i];
      assign qin = qr[i];
    end

    always_ff @(posedge clk) begin
      if (step_en[i]) begin
        qr[i+1] <= qin;
        if (!zin[cpt_pkg::CORDIC_ZBITS-1]) begin
          xr[i+1] <= xin - (yin >>> i);
          yr[i+1] <= yin + (xin >>> i);
          zr[i+1] <= zin - cpt_pkg::ATAN[i];
        end else begin
          xr[i+1] <= xin + (yin >>> i);
          yr[i+1] <= yin - (xin >>> i);
          zr[i+1] <= zin + cpt_pkg::ATAN[i];
        end
      end
    end
  end

  cpt_pkg::q15_t  cq;
  cpt_pkg::q15_t  sq;
  cpt_pkg::trig_t cq_ext;
  cpt_pkg::trig_t sq_ext;
  cpt_pkg::trig_t cos_next;
  cpt_pkg::trig_t sin_next;

  assign cq     = cpt_pkg::to_q15(xr[STEPS]);
  assign sq     = cpt_pkg::to_q15(yr[STEPS]);
  assign cq_ext = cpt_pkg::trig_t'(cq);
  assign sq_ext = cpt_pkg::trig_t'(sq);

  // first quadrant values folded out to the full turn
  always_comb begin
    case (qr[STEPS])
      2'd0: begin
        cos_next = cq_ext;
        sin_next = sq_ext;
      end
      2'd1: begin
        cos_next = -sq_ext;
        sin_next = cq_ext;
      end
      2'd2: begin
        cos_next = -cq_ext;
        sin_next = -sq_ext;
      end
      default: begin
        cos_next = sq_ext;
        sin_next = -cq_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (step_en[STEPS]) begin
      cos_val <= cos_next;
      sin_val <= sin_next;
    end
  end

endmodule
